/* design/tskt_pkg.sv */
// ----------------------------------------------------------------------------
// tskt_pkg
// Shared widths, element codes and types for the speculation key tracker.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package tskt_pkg;

  localparam int unsigned OpW     = 4;
  localparam int unsigned MaskW   = 4;
  localparam int unsigned InfoW   = 8;
  localparam int unsigned KeyW    = 32;
  localparam int unsigned DepthW  = 32;
  localparam int unsigned ThrW    = 12;
  localparam int unsigned AmtW    = 32;
  localparam int unsigned StampW  = 64;
  localparam int unsigned RepW    = 7;
  localparam int unsigned CyclesW = 33;
  localparam int unsigned CfgIdxW = 1;
  localparam int unsigned CfgW    = 32;

  // dividend of the remainder unit: one bit above the key
  localparam int unsigned DvdW    = KeyW + 1;

  localparam int unsigned InDataW  = 192;
  localparam int unsigned OutDataW = 176;

  localparam logic [OpW-1:0] OP_INFO      = 4'd0;
  localparam logic [OpW-1:0] OP_ATOM_E    = 4'd1;
  localparam logic [OpW-1:0] OP_ATOM_N    = 4'd2;
  localparam logic [OpW-1:0] OP_Q         = 4'd3;
  localparam logic [OpW-1:0] OP_EXCEPTION = 4'd4;
  localparam logic [OpW-1:0] OP_COMMIT    = 4'd5;
  localparam logic [OpW-1:0] OP_CANCEL    = 4'd6;
  localparam logic [OpW-1:0] OP_DISCARD   = 4'd7;
  localparam logic [OpW-1:0] OP_TIMESTAMP = 4'd8;
  localparam logic [OpW-1:0] OP_CYCLES    = 4'd9;

  localparam logic [CfgIdxW-1:0] CFG_KEY_MODULUS = 1'd0;
  localparam logic [CfgIdxW-1:0] CFG_DEPTH_LIMIT = 1'd1;

  localparam int unsigned MaskInfoBit  = 0;
  localparam int unsigned MaskKeyBit   = 1;
  localparam int unsigned MaskDepthBit = 2;
  localparam int unsigned MaskThrBit   = 3;

  typedef struct packed {
    logic busy;
    logic done;
  } mod_status_t;

endpackage

`default_nettype wire

/* design/tskt_mod_unit.sv */
// ----------------------------------------------------------------------------
// tskt_mod_unit
// Bit-serial restoring remainder unit, one dividend bit per cycle.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module tskt_mod_unit
  import tskt_pkg::*;
(
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              start_i,
  input  wire logic [DvdW-1:0]   dividend_i,
  input  wire logic [KeyW-1:0]   divisor_i,
  output mod_status_t            status_o,
  output logic      [KeyW-1:0]   rem_o
);

  localparam int unsigned CntW = $clog2(DvdW);
  localparam logic [CntW-1:0] CntLast = CntW'(DvdW - 1);

  logic            busy_q, busy_d;
  logic            done_q, done_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic [DvdW-1:0] dvd_q, dvd_d;
  logic [KeyW-1:0] div_q, div_d;
  logic [KeyW-1:0] rem_q, rem_d;
  logic [KeyW:0]   shl;
  logic [KeyW:0]   step;

  always_comb begin
    shl  = {rem_q, dvd_q[DvdW-1]};
    if (shl >= {1'b0, div_q}) begin
      step = shl - {1'b0, div_q};
    end else begin
      step = shl;
    end

    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    dvd_d  = dvd_q;
    div_d  = div_q;
    rem_d  = rem_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = CntLast;
      dvd_d  = dividend_i;
      div_d  = divisor_i;
      rem_d  = '0;
    end else if (busy_q) begin
      rem_d = step[KeyW-1:0];
      dvd_d = {dvd_q[DvdW-2:0], 1'b0};
      cnt_d = cnt_q - CntW'(1);
      if (cnt_q == '0) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    dvd_q <= dvd_d;
    div_q <= div_d;
    rem_q <= rem_d;
  end

  assign status_o.busy = busy_q;
  assign status_o.done = done_q;
  assign rem_o         = rem_q;

endmodule

`default_nettype wire

/* design/trace_speculation_key_tracker_core.sv */
// ----------------------------------------------------------------------------
// trace_speculation_key_tracker_core
// Tracks P0 key, speculation depth, info, threshold and timestamp per element.
// ----------------------------------------------------------------------------
// Usage:
//   One decoded trace element is a request on the s_axis channel (tuser holds
//   the element code, tdata the operands). Each request gives exactly one
//   result on m_axis, reporting the tracker state after the element.
//   cfg_* writes key_modulus (index 0) and depth_limit (index 1); write only
//   while no request is in flight.
//   s_axis_tready is high only while the sequencer is idle. Elements that
//   need no key remainder pass from the decode step straight to the final step.
//   Key advance with a nonzero modulus runs the bit-serial remainder unit once
//   over all 33 dividend bits; cancel with a nonzero modulus runs it twice.
//   Both runs use the single shared remainder unit.
//   The result sits in an output register; a new request is taken while it
//   waits. If the receiver stalls, the next result holds in the final step
//   until the register frees.
//   Reset clears the tracker state, the result valid and both configuration registers to zero.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module trace_speculation_key_tracker_core
  import tskt_pkg::*;
(
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  // configuration write
  input  wire logic                cfg_valid_i,
  output logic                     cfg_ready_o,
  input  wire logic [CfgIdxW-1:0]  cfg_index_i,
  input  wire logic [CfgW-1:0]     cfg_data_i,
  // element request
  input  wire logic                s_axis_tvalid,
  output logic                     s_axis_tready,
  // presence_mask, info_byte, key_value, depth_value, threshold_value,
  // amount, stamp_bits, replace_width, flag
  input  wire logic [InDataW-1:0]  s_axis_tdata,
  // operation
  input  wire logic [OpW-1:0]      s_axis_tuser,
  // result
  output logic                     m_axis_tvalid,
  input  wire logic                m_axis_tready,
  // committed, current_key, current_depth, current_stamp, cycles,
  // cycles_known, info_now, zero pad
  output logic [OutDataW-1:0]      m_axis_tdata
);

  localparam logic [2:0] ST_IDLE   = 3'd0;
  localparam logic [2:0] ST_DECODE = 3'd1;
  localparam logic [2:0] ST_MOD_A  = 3'd2;
  localparam logic [2:0] ST_MOD_B  = 3'd3;
  localparam logic [2:0] ST_FIN    = 3'd4;

  logic [2:0]        state_q, state_d;

  logic [KeyW-1:0]   key_modulus_q;
  logic [DepthW-1:0] depth_limit_q;

  logic [KeyW-1:0]   key_q, key_d;
  logic [DepthW-1:0] depth_q, depth_d;
  logic [InfoW-1:0]  info_q, info_d;
  logic [ThrW-1:0]   thr_q, thr_d;
  logic [StampW-1:0] stamp_q, stamp_d;
  logic [KeyW-1:0]   key_rem_q;

  logic [OpW-1:0]    op_q;
  logic [MaskW-1:0]  mask_q;
  logic [InfoW-1:0]  in_info_q;
  logic [KeyW-1:0]   in_key_q;
  logic [DepthW-1:0] in_depth_q;
  logic [ThrW-1:0]   in_thr_q;
  logic [AmtW-1:0]   amount_q;
  logic [StampW-1:0] in_stamp_q;
  logic [RepW-1:0]   rep_width_q;
  logic              flag_q;

  logic                out_valid_q;
  logic [OutDataW-1:0] out_data_q;

  logic              accept;
  logic              out_free;
  logic              is_p0;
  logic              is_cancel;
  logic              mod_on;
  logic              mod_start;
  logic [DvdW-1:0]   mod_dvd;
  logic [KeyW-1:0]   mod_rem;
  mod_status_t       mod_st;

  logic              committed;
  logic [CyclesW-1:0] cycles;
  logic              cycles_known;
  logic [DepthW-1:0] depth_inc;
  logic [KeyW:0]     cancel_sum;
  logic [KeyW-1:0]   cancel_key;

  assign accept    = s_axis_tvalid && s_axis_tready;
  assign out_free  = !out_valid_q || m_axis_tready;
  assign is_p0     = (op_q == OP_ATOM_E) || (op_q == OP_ATOM_N) || (op_q == OP_Q) ||
                     (op_q == OP_EXCEPTION);
  assign is_cancel = (op_q == OP_CANCEL);
  assign mod_on    = (key_modulus_q != '0);

  assign cfg_ready_o   = 1'b1;
  assign s_axis_tready = (state_q == ST_IDLE);
  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;

  // remainder unit operand select
  always_comb begin
    mod_start = 1'b0;
    mod_dvd   = {1'b0, key_q} + DvdW'(1);
    if (state_q == ST_DECODE) begin
      mod_start = mod_on && (is_p0 || is_cancel);
      mod_dvd   = is_cancel ? {1'b0, key_q} : ({1'b0, key_q} + DvdW'(1));
    end else if (state_q == ST_MOD_A) begin
      mod_start = mod_st.done && is_cancel;
      mod_dvd   = {1'b0, amount_q};
    end
  end

  tskt_mod_unit u_mod (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (mod_start),
    .dividend_i (mod_dvd),
    .divisor_i  (key_modulus_q),
    .status_o   (mod_st),
    .rem_o      (mod_rem)
  );

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (accept) state_d = ST_DECODE;
      end
      ST_DECODE: begin
        state_d = mod_start ? ST_MOD_A : ST_FIN;
      end
      ST_MOD_A: begin
        if (mod_st.done) state_d = is_cancel ? ST_MOD_B : ST_FIN;
      end
      ST_MOD_B: begin
        if (mod_st.done) state_d = ST_FIN;
      end
      ST_FIN: begin
        if (out_free) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // element update
  always_comb begin
    key_d        = key_q;
    depth_d      = depth_q;
    info_d       = info_q;
    thr_d        = thr_q;
    stamp_d      = stamp_q;
    committed    = 1'b0;
    cycles       = '0;
    cycles_known = 1'b0;
    depth_inc    = depth_q + DepthW'(1);
    cancel_sum   = {1'b0, key_rem_q} + {1'b0, key_modulus_q} - {1'b0, mod_rem};
    if (cancel_sum >= {1'b0, key_modulus_q}) begin
      cancel_key = KeyW'(cancel_sum - {1'b0, key_modulus_q});
    end else begin
      cancel_key = cancel_sum[KeyW-1:0];
    end

    unique case (op_q) inside
      OP_INFO: begin
        info_d  = mask_q[MaskInfoBit]  ? in_info_q  : '0;
        key_d   = mask_q[MaskKeyBit]   ? in_key_q   : '0;
        depth_d = mask_q[MaskDepthBit] ? in_depth_q : '0;
        thr_d   = mask_q[MaskThrBit]   ? in_thr_q   : '0;
      end
      OP_ATOM_E, OP_ATOM_N, OP_Q, OP_EXCEPTION: begin
        if (mod_on) key_d = mod_rem;
        if ((depth_limit_q == '0) || (depth_inc > depth_limit_q)) begin
          committed = 1'b1;
        end else begin
          depth_d = depth_inc;
        end
      end
      OP_COMMIT: begin
        depth_d = depth_q - amount_q;
      end
      OP_CANCEL: begin
        depth_d = depth_q - amount_q;
        if (mod_on) key_d = cancel_key;
      end
      OP_DISCARD: begin
        depth_d = '0;
      end
      OP_TIMESTAMP: begin
        if (in_stamp_q != '0) begin
          if (rep_width_q[RepW-1]) begin
            stamp_d = in_stamp_q;
          end else begin
            stamp_d = (stamp_q & ({StampW{1'b1}} << rep_width_q[RepW-2:0])) | in_stamp_q;
          end
        end
      end
      OP_CYCLES: begin
        if (!flag_q) begin
          cycles       = {1'b0, amount_q} + CyclesW'(thr_q);
          cycles_known = 1'b1;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= ST_IDLE;
      key_modulus_q <= '0;
      depth_limit_q <= '0;
      key_q         <= '0;
      depth_q       <= '0;
      info_q        <= '0;
      thr_q         <= '0;
      stamp_q       <= '0;
      out_valid_q   <= 1'b0;
    end else begin
      state_q <= state_d;
      if (cfg_valid_i) begin
        unique case (cfg_index_i)
          CFG_KEY_MODULUS: key_modulus_q <= cfg_data_i;
          CFG_DEPTH_LIMIT: depth_limit_q <= cfg_data_i;
          default: ;
        endcase
      end
      if ((state_q == ST_FIN) && out_free) begin
        key_q       <= key_d;
        depth_q     <= depth_d;
        info_q      <= info_d;
        thr_q       <= thr_d;
        stamp_q     <= stamp_d;
        out_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      op_q        <= s_axis_tuser;
      mask_q      <= s_axis_tdata[3:0];
      in_info_q   <= s_axis_tdata[11:4];
      in_key_q    <= s_axis_tdata[43:12];
      in_depth_q  <= s_axis_tdata[75:44];
      in_thr_q    <= s_axis_tdata[87:76];
      amount_q    <= s_axis_tdata[119:88];
      in_stamp_q  <= s_axis_tdata[183:120];
      rep_width_q <= s_axis_tdata[190:184];
      flag_q      <= s_axis_tdata[191];
    end
    if ((state_q == ST_MOD_A) && mod_st.done) begin
      key_rem_q <= mod_rem;
    end
    if ((state_q == ST_FIN) && out_free) begin
      out_data_q <= {5'd0, info_d, cycles_known, cycles, stamp_d, depth_d, key_d,
                     committed};
    end
  end

  // remainder unit only runs under the sequencer's remainder steps
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    mod_st.busy |-> ((state_q == ST_MOD_A) || (state_q == ST_MOD_B)))
    else $error("remainder unit busy outside remainder step");

  // a new result only appears from the final step
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_axis_tvalid) |-> $past(state_q == ST_FIN))
    else $error("result raised outside final step");

  // key advance or cancel leaves the key below a nonzero modulus
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((state_q == ST_FIN) && out_free && (is_p0 || is_cancel) && mod_on && !cfg_valid_i)
      |=> (key_q < key_modulus_q))
    else $error("key not reduced by modulus");

  // no request taken while an element is in flight
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != ST_IDLE) |-> !s_axis_tready)
    else $error("request taken while busy");

endmodule

`default_nettype wire
